[rtl/ptfs_pkg.sv]
`timescale 1ns / 1ps

package ptfs_pkg;

    localparam int OPCODE_W = 2;
    localparam int PERIOD_W = 16;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int STAG_W   = 8;

    localparam logic [STAG_W-1:0] STAGGER_STEP = 8'd23;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd3;

    // Result kinds and status codes.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_TASK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

    // Operations of the slot update unit.
    localparam logic [1:0] SU_PASS  = 2'd0;
    localparam logic [1:0] SU_TICK  = 2'd1;
    localparam logic [1:0] SU_CLEAR = 2'd2;
    localparam logic [1:0] SU_LOAD  = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] countdown;
        logic                ready;
    } t_entry;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id_out;
        logic [COUNT_W-1:0]  tasks_in_table;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [1:0]          op;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     task_id;
        logic [STAG_W-1:0]   stagger;
    } t_slot_ctrl;

endpackage

[rtl/ptfs_in_if.sv]
`timescale 1ns / 1ps

interface ptfs_in_if;
    logic                             valid;
    logic                             ready;
    logic [ptfs_pkg::OPCODE_W-1:0]    opcode;
    logic [ptfs_pkg::PERIOD_W-1:0]    period;
    logic [ptfs_pkg::ID_W-1:0]        task_id;

    modport source (output valid, output opcode, output period, output task_id,
                    input ready);
    modport sink   (input valid, input opcode, input period, input task_id,
                    output ready);
endinterface

[rtl/ptfs_out_if.sv]
`timescale 1ns / 1ps

interface ptfs_out_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [ptfs_pkg::STATUS_W-1:0]    status;
    logic [ptfs_pkg::ID_W-1:0]        task_id_out;
    logic [ptfs_pkg::COUNT_W-1:0]     tasks_in_table;
    logic                             last;

    modport source (output valid, output kind, output status, output task_id_out,
                    output tasks_in_table, output last, input ready);
    modport sink   (input valid, input kind, input status, input task_id_out,
                    input tasks_in_table, input last, output ready);
endinterface

[rtl/ptfs_slot_unit.sv]
`timescale 1ns / 1ps

module ptfs_slot_unit (
    input  ptfs_pkg::t_slot_ctrl i_ctrl,
    input  ptfs_pkg::t_entry     i_entry,
    output ptfs_pkg::t_entry     o_entry
);

    always_comb begin
        o_entry = i_entry;
        unique case (i_ctrl.op)
            ptfs_pkg::SU_PASS: begin
                o_entry = i_entry;
            end
            ptfs_pkg::SU_TICK: begin
                // A zero countdown is parked: it never moves again on a tick.
                if (i_entry.countdown != '0) begin
                    if (i_entry.countdown == ptfs_pkg::PERIOD_W'(1)) begin
                        o_entry.countdown = i_entry.period;
                        o_entry.ready     = 1'b1;
                    end else begin
                        o_entry.countdown = i_entry.countdown - ptfs_pkg::PERIOD_W'(1);
                    end
                end
            end
            ptfs_pkg::SU_CLEAR: begin
                o_entry.ready = 1'b0;
            end
            ptfs_pkg::SU_LOAD: begin
                o_entry.task_id   = i_ctrl.task_id;
                o_entry.period    = i_ctrl.period;
                o_entry.countdown = i_ctrl.period
                                  + {{(ptfs_pkg::PERIOD_W-ptfs_pkg::STAG_W){1'b0}},
                                     i_ctrl.stagger};
                o_entry.ready     = 1'b0;
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule

[rtl/periodic_task_flag_scheduler.sv]
`timescale 1ns / 1ps

// Channel   Direction  Signals
// i_in      sink       valid, ready, opcode, period, task_id
// o_out     source     valid, ready, kind, status, task_id_out, tasks_in_table, last
//
// The task table is a single-write, single-read memory visited one slot per cycle
// while dispatch holds no slot. Add writes its slot straight from idle; tick and
// dispatch visit each of the N tasks held, and delete scans for the ID, then moves the
// last slot into the hole. Dispatch holds a slot while an earlier task beat is still
// waiting at the output register, so a stalled sink lengthens it. Reset (synchronous,
// active low) empties the table and clears the stagger; no clearing pass is needed.

module periodic_task_flag_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptfs_in_if.sink         i_in,
    ptfs_out_if.source      o_out
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TICK     = 3'd1;
    localparam logic [2:0] S_DEL_SCAN = 3'd2;
    localparam logic [2:0] S_DEL_MOVE = 3'd3;
    localparam logic [2:0] S_DISP     = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_count, n_count;
    logic [ptfs_pkg::STAG_W-1:0]   r_stagger, n_stagger;
    logic [ptfs_pkg::ID_W-1:0]     r_id, n_id;
    logic                          r_pend_v, n_pend_v;
    logic [ptfs_pkg::ID_W-1:0]     r_pend_id, n_pend_id;
    ptfs_pkg::t_result             r_fin, n_fin;
    logic                          r_out_valid;
    ptfs_pkg::t_result             r_out, out_data;
    logic                          out_load;
    logic                          out_free;

    ptfs_pkg::t_entry              r_mem [MAX_TASKS];
    ptfs_pkg::t_entry              r_rdata;
    logic [IW-1:0]                 mem_raddr;
    logic [IW-1:0]                 mem_waddr;
    logic                          mem_we;
    ptfs_pkg::t_entry              mem_wdata;

    ptfs_pkg::t_slot_ctrl          su_ctrl;
    ptfs_pkg::t_entry              su_out;

    logic [IW-1:0]                 last_idx;
    logic [IW-1:0]                 next_idx;
    logic                          at_last;

    ptfs_slot_unit u_slot (
        .i_ctrl  (su_ctrl),
        .i_entry (r_rdata),
        .o_entry (su_out)
    );

    assign last_idx = IW'(r_count - CW'(1));
    assign next_idx = IW'(r_idx + IW'(1));
    assign at_last  = (r_idx == last_idx);
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_stagger = r_stagger;
        n_id      = r_id;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        n_fin     = r_fin;
        mem_raddr = r_idx;
        mem_waddr = r_idx;
        mem_we    = 1'b0;
        mem_wdata = su_out;
        out_load  = 1'b0;
        out_data  = r_fin;
        su_ctrl.op      = ptfs_pkg::SU_PASS;
        su_ctrl.period  = i_in.period;
        su_ctrl.task_id = i_in.task_id;
        su_ctrl.stagger = r_stagger;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_id              = i_in.task_id;
                    n_idx             = '0;
                    mem_raddr         = '0;
                    n_pend_v          = 1'b0;
                    n_fin.kind        = ptfs_pkg::KIND_ACK;
                    n_fin.status      = ptfs_pkg::ST_OK;
                    n_fin.task_id_out = i_in.task_id;
                    n_fin.last        = 1'b1;
                    n_fin.tasks_in_table = '0;
                    unique case (i_in.opcode)
                        ptfs_pkg::OP_TICK: begin
                            n_state = (r_count == '0) ? S_EMIT : S_TICK;
                        end
                        ptfs_pkg::OP_ADD: begin
                            if (r_count == CW'(MAX_TASKS)) begin
                                n_fin.status = ptfs_pkg::ST_FULL;
                            end else begin
                                su_ctrl.op = ptfs_pkg::SU_LOAD;
                                mem_we     = 1'b1;
                                mem_waddr  = r_count[IW-1:0];
                                n_count    = r_count + CW'(1);
                                n_stagger  = r_stagger + ptfs_pkg::STAGGER_STEP;
                            end
                            n_state = S_EMIT;
                        end
                        ptfs_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_fin.status = ptfs_pkg::ST_NOT_FOUND;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_DEL_SCAN;
                            end
                        end
                        ptfs_pkg::OP_DISPATCH: begin
                            if (r_count == '0) begin
                                n_fin.status = ptfs_pkg::ST_NONE;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_TICK: begin
                su_ctrl.op = ptfs_pkg::SU_TICK;
                mem_we     = 1'b1;
                if (at_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx     = next_idx;
                    mem_raddr = next_idx;
                end
            end

            S_DEL_SCAN: begin
                if (r_rdata.task_id == r_id) begin
                    // Fetch the last slot; it moves into the hole next cycle.
                    mem_raddr = last_idx;
                    n_state   = S_DEL_MOVE;
                end else if (at_last) begin
                    n_fin.status = ptfs_pkg::ST_NOT_FOUND;
                    n_state      = S_EMIT;
                end else begin
                    n_idx     = next_idx;
                    mem_raddr = next_idx;
                end
            end

            S_DEL_MOVE: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_count   = r_count - CW'(1);
                n_state   = S_EMIT;
            end

            S_DISP: begin
                if (r_rdata.ready && r_pend_v && !out_free) begin
                    // Hold this slot until the earlier task beat has gone.
                    mem_raddr = r_idx;
                end else begin
                    if (r_rdata.ready) begin
                        su_ctrl.op = ptfs_pkg::SU_CLEAR;
                        mem_we     = 1'b1;
                        n_pend_v   = 1'b1;
                        n_pend_id  = r_rdata.task_id;
                        if (r_pend_v) begin
                            out_load             = 1'b1;
                            out_data.kind        = ptfs_pkg::KIND_TASK;
                            out_data.status      = ptfs_pkg::ST_OK;
                            out_data.task_id_out = r_pend_id;
                            out_data.last        = 1'b0;
                        end
                    end
                    if (at_last) begin
                        if (n_pend_v) begin
                            n_fin.kind        = ptfs_pkg::KIND_TASK;
                            n_fin.status      = ptfs_pkg::ST_OK;
                            n_fin.task_id_out = n_pend_id;
                        end else begin
                            n_fin.status = ptfs_pkg::ST_NONE;
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_idx     = next_idx;
                        mem_raddr = next_idx;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        out_data.tasks_in_table = ptfs_pkg::COUNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_stagger   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_stagger <= n_stagger;
            r_pend_v  <= n_pend_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_pend_id <= n_pend_id;
        r_fin     <= n_fin;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.status         = r_out.status;
    assign o_out.task_id_out    = r_out.task_id_out;
    assign o_out.tasks_in_table = r_out.tasks_in_table;
    assign o_out.last           = r_out.last;

endmodule
